@@ hdl/ecpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ecpu_pkg;

   localparam int DATA_W    = 8;
   localparam int ADDR_W    = 8;
   localparam int MEM_DEPTH = 256;
   localparam int STEP_W    = 5;
   localparam int GPR_COUNT = 4;

   typedef enum logic [1:0] {
      OPK_TICK  = 2'd0,
      OPK_WRITE = 2'd1,
      OPK_READ  = 2'd2,
      OPK_NOP   = 2'd3
   } op_kind_type;

   typedef enum logic [3:0] {
      OPC_AND   = 4'h0,
      OPC_OR    = 4'h1,
      OPC_XOR   = 4'h2,
      OPC_ADD   = 4'h3,
      OPC_SUB   = 4'h4,
      OPC_NOT   = 4'h5,
      OPC_SHR   = 4'h6,
      OPC_SHL   = 4'h7,
      OPC_LOAD  = 4'h8,
      OPC_WRT   = 4'h9,
      OPC_JMPZ  = 4'hA,
      OPC_JMP   = 4'hB,
      OPC_LOADL = 4'hC,
      OPC_WRTL  = 4'hD,
      OPC_HALT  = 4'hF
   } opcode_type;

   typedef enum logic [STEP_W-1:0] {
      CS_FETCH        = 5'd0,
      CS_ALU_WB       = 5'd1,
      CS_SAVE_RET     = 5'd2,
      CS_REG_ADDR     = 5'd3,
      CS_INC_REQ      = 5'd4,
      CS_INC_WAIT     = 5'd5,
      CS_PC_REQ       = 5'd6,
      CS_PC_WAIT      = 5'd7,
      CS_LOAD_WB      = 5'd8,
      CS_STORE        = 5'd9,
      CS_STORE_WAIT   = 5'd10,
      CS_RESTORE      = 5'd11,
      CS_RESTORE_WAIT = 5'd12,
      CS_SKIP_WAIT    = 5'd13,
      CS_SKIP_INC     = 5'd14,
      CS_JUMP         = 5'd15,
      CS_JUMP_WAIT    = 5'd16,
      CS_NEXT_WAIT    = 5'd17,
      CS_HALT         = 5'd18,
      CS_ALU_WAIT     = 5'd19,
      CS_LOAD_WAIT    = 5'd20
   } ctrl_state_type;

   typedef enum logic {
      PH_IDLE   = 1'b0,
      PH_FINISH = 1'b1
   } phase_type;

   typedef struct packed {
      logic mem_ack;
      logic mem_req;
      logic inc_ack;
      logic inc_req;
      logic pc_ack;
      logic pc_req;
      logic reg_ack;
      logic reg_req;
   } hs_type;

   typedef struct packed {
      logic [DATA_W-1:0] instruction;
      logic [DATA_W-1:0] return_address;
      logic [DATA_W-1:0] pc_load_value;
      logic [DATA_W-1:0] fetched_operand;
      logic [DATA_W-1:0] register_load_value;
      logic [DATA_W-1:0] memory_write_value;
      hs_type            flags;
      ctrl_state_type    step;
      logic              halt;
   } ctrl_regs_type;

endpackage

`default_nettype wire

@@ hdl/ecpu_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ecpu_req_if
   import ecpu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output operation, output address, output write_data,
                   input ready);
   modport sink (input valid, input operation, input address, input write_data,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/ecpu_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ecpu_rsp_if
   import ecpu_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              halted;
   logic [ADDR_W-1:0] program_counter;
   logic [DATA_W-1:0] read_data;
   logic [STEP_W-1:0] controller_step;

   modport source (output valid, output halted, output program_counter, output read_data,
                   output controller_step, input ready);
   modport sink (input valid, input halted, input program_counter, input read_data,
                 input controller_step, output ready);
endinterface

`default_nettype wire

@@ hdl/ecpu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ecpu_ctrl
   import ecpu_pkg::*;
   (
   input  ctrl_regs_type     cur,
   input  logic [ADDR_W-1:0] pc,
   input  logic [DATA_W-1:0] operand_a,
   input  logic [DATA_W-1:0] operand_b,
   input  logic [DATA_W-1:0] latch,
   output ctrl_regs_type     nxt
   );

   opcode_type op;

   assign op = opcode_type'(cur.instruction[7:4]);

   always_comb begin
      nxt = cur;
      case (cur.step)
         CS_FETCH: begin
            nxt.instruction = latch;
            nxt.step = latch[7] ? CS_SAVE_RET : CS_ALU_WB;
         end
         CS_ALU_WB: begin
            nxt.flags.reg_req = 1'b1;
            nxt.step = CS_ALU_WAIT;
         end
         CS_SAVE_RET: begin
            nxt.return_address = pc;
            nxt.step = (op == OPC_LOADL || op == OPC_WRTL) ? CS_REG_ADDR : CS_INC_REQ;
         end
         CS_REG_ADDR: begin
            nxt.pc_load_value = operand_a;
            nxt.step = CS_PC_REQ;
         end
         CS_INC_REQ: begin
            nxt.flags.inc_req = 1'b1;
            nxt.step = CS_INC_WAIT;
         end
         CS_INC_WAIT: begin
            if (cur.flags.inc_ack) begin
               nxt.flags.inc_req = 1'b0;
               nxt.pc_load_value = latch;
               nxt.step = CS_PC_REQ;
            end
         end
         CS_PC_REQ: begin
            nxt.flags.pc_req = 1'b1;
            nxt.step = CS_PC_WAIT;
         end
         CS_PC_WAIT: begin
            if (cur.flags.pc_ack) begin
               nxt.flags.pc_req = 1'b0;
               nxt.fetched_operand = latch;
               case (op)
                  OPC_LOAD, OPC_LOADL: nxt.step = CS_LOAD_WB;
                  OPC_WRT, OPC_WRTL:   nxt.step = CS_STORE;
                  OPC_JMPZ:            nxt.step = (operand_b == '0) ? CS_JUMP : CS_RESTORE;
                  OPC_JMP:             nxt.step = CS_JUMP;
                  OPC_HALT:            nxt.step = CS_HALT;
                  default:             nxt.step = cur.step;
               endcase
            end
         end
         CS_LOAD_WB: begin
            nxt.register_load_value = cur.fetched_operand;
            nxt.flags.reg_req = 1'b1;
            nxt.step = CS_LOAD_WAIT;
         end
         CS_STORE: begin
            nxt.memory_write_value = operand_b;
            nxt.flags.mem_req = 1'b1;
            nxt.step = CS_STORE_WAIT;
         end
         CS_STORE_WAIT: begin
            if (cur.flags.mem_ack) begin
               nxt.flags.mem_req = 1'b0;
               nxt.step = CS_RESTORE;
            end
         end
         CS_RESTORE: begin
            nxt.pc_load_value = cur.return_address;
            nxt.flags.pc_req = 1'b1;
            nxt.step = CS_RESTORE_WAIT;
         end
         CS_RESTORE_WAIT: begin
            if (cur.flags.pc_ack) begin
               nxt.flags.pc_req = 1'b0;
               nxt.flags.inc_req = 1'b1;
               nxt.step = (op != OPC_LOADL && op != OPC_WRTL) ? CS_SKIP_WAIT : CS_NEXT_WAIT;
            end
         end
         CS_SKIP_WAIT: begin
            if (cur.flags.inc_ack) begin
               nxt.flags.inc_req = 1'b0;
               nxt.step = CS_SKIP_INC;
            end
         end
         CS_SKIP_INC: begin
            nxt.flags.inc_req = 1'b1;
            nxt.step = CS_NEXT_WAIT;
         end
         CS_JUMP: begin
            nxt.pc_load_value = cur.fetched_operand;
            nxt.flags.pc_req = 1'b1;
            nxt.step = CS_JUMP_WAIT;
         end
         CS_JUMP_WAIT: begin
            if (cur.flags.pc_ack) begin
               nxt.flags.pc_req = 1'b0;
               nxt.step = CS_FETCH;
            end
         end
         CS_NEXT_WAIT: begin
            if (cur.flags.inc_ack) begin
               nxt.flags.inc_req = 1'b0;
               nxt.step = CS_FETCH;
            end
         end
         CS_HALT: begin
            nxt.halt = 1'b1;
         end
         CS_ALU_WAIT: begin
            if (cur.flags.reg_ack) begin
               nxt.flags.reg_req = 1'b0;
               nxt.flags.inc_req = 1'b1;
               nxt.step = CS_NEXT_WAIT;
            end
         end
         CS_LOAD_WAIT: begin
            if (cur.flags.reg_ack) begin
               nxt.flags.reg_req = 1'b0;
               nxt.step = CS_RESTORE;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/eight_bit_multicycle_cpu_core.sv @@
// Sequence: when a word is accepted, the datapath units run and the memory access starts;
// in the finish phase, the memory read data is taken into the response registers.
// A new word is taken only in the idle phase and while no earlier response is held unread.
// Reset: synchronous; registers, handshake flags, program counter and controller clear,
// memory contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_multicycle_cpu_core
   import ecpu_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   ecpu_req_if.sink   req,
   ecpu_rsp_if.source rsp
   );

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] mem_rdata_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wdata;

   phase_type         phase_ff, phase_in;
   op_kind_type       op_ff, op_in;

   ctrl_regs_type     ctrl_ff, ctrl_in, ctrl_nxt;
   logic [DATA_W-1:0] gpr_ff [GPR_COUNT];
   logic [DATA_W-1:0] gpr_in [GPR_COUNT];
   logic [DATA_W-1:0] opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic [DATA_W-1:0] alu_ff, alu_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_halted_ff, rsp_halted_in;
   logic [ADDR_W-1:0] rsp_pc_ff, rsp_pc_in;
   logic [DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic [STEP_W-1:0] rsp_step_ff, rsp_step_in;

   logic              req_ready;
   logic              accept;
   logic              finish;
   op_kind_type       req_op;
   opcode_type        opc;
   hs_type            flags_u;
   logic [1:0]        dst;
   logic [1:0]        src;
   logic              tick_we;

   assign req_op    = op_kind_type'(req.operation);
   assign req_ready = (phase_ff == PH_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = req_ready;
   assign accept    = req.valid && req_ready;
   assign finish    = (phase_ff == PH_FINISH);
   assign opc       = opcode_type'(ctrl_ff.instruction[7:4]);
   assign dst       = ctrl_ff.instruction[1:0];
   assign src       = ctrl_ff.instruction[3:2];

   always_comb begin
      flags_u = ctrl_ff.flags;
      gpr_in  = gpr_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      alu_in  = alu_ff;
      pc_in   = pc_ff;
      tick_we = 1'b0;

      if (accept && req_op == OPK_TICK) begin
         if (flags_u.reg_req && !flags_u.reg_ack) begin
            gpr_in[dst] = ctrl_ff.instruction[7] ? ctrl_ff.register_load_value : alu_ff;
            flags_u.reg_ack = 1'b1;
         end
         if (!flags_u.reg_req && flags_u.reg_ack) begin
            flags_u.reg_ack = 1'b0;
         end

         if (opc < OPC_NOT || opc == OPC_LOADL || opc == OPC_WRTL) begin
            opa_in = gpr_in[src];
            opb_in = gpr_in[dst];
         end else if (opc < OPC_JMP) begin
            opb_in = gpr_in[dst];
         end

         case (opc)
            OPC_AND: alu_in = opb_in & opa_in;
            OPC_OR:  alu_in = opb_in | opa_in;
            OPC_XOR: alu_in = opb_in ^ opa_in;
            OPC_ADD: alu_in = opb_in + opa_in;
            OPC_SUB: alu_in = opb_in - opa_in;
            OPC_NOT: alu_in = ~opb_in;
            OPC_SHR: alu_in = {1'b0, opb_in[DATA_W-1:1]};
            OPC_SHL: alu_in = {opb_in[DATA_W-2:0], 1'b0};
            default: alu_in = '0;
         endcase

         if (flags_u.pc_req && !flags_u.pc_ack) begin
            pc_in = ctrl_ff.pc_load_value;
            flags_u.pc_ack = 1'b1;
         end
         if (!flags_u.pc_req && flags_u.pc_ack) begin
            flags_u.pc_ack = 1'b0;
         end
         if (flags_u.inc_req && !flags_u.inc_ack) begin
            pc_in = pc_in + ADDR_W'(1);
            flags_u.inc_ack = 1'b1;
         end
         if (!flags_u.inc_req && flags_u.inc_ack) begin
            flags_u.inc_ack = 1'b0;
         end

         if (flags_u.mem_req && !flags_u.mem_ack) begin
            tick_we = 1'b1;
            flags_u.mem_ack = 1'b1;
         end
         if (!flags_u.mem_req && flags_u.mem_ack) begin
            flags_u.mem_ack = 1'b0;
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = req.address;
      mem_wdata = req.write_data;
      if (accept) begin
         case (req_op)
            OPK_TICK: begin
               mem_we    = tick_we;
               mem_addr  = pc_in;
               mem_wdata = ctrl_ff.memory_write_value;
            end
            OPK_WRITE: begin
               mem_we = 1'b1;
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem_we ? mem_wdata : mem[mem_addr];
   end

   ecpu_ctrl u_ctrl (
      .cur       (ctrl_ff),
      .pc        (pc_ff),
      .operand_a (opa_ff),
      .operand_b (opb_ff),
      .latch     (mem_rdata_ff),
      .nxt       (ctrl_nxt)
   );

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      ctrl_in  = ctrl_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               phase_in = PH_FINISH;
               op_in    = req_op;
               ctrl_in.flags = flags_u;
            end
         end
         PH_FINISH: begin
            phase_in = PH_IDLE;
            if (op_ff == OPK_TICK) begin
               ctrl_in = ctrl_nxt;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_halted_in = rsp_halted_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_step_in   = rsp_step_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_halted_in = ctrl_in.halt;
         rsp_pc_in     = pc_ff;
         rsp_rdata_in  = (op_ff == OPK_READ) ? mem_rdata_ff : '0;
         rsp_step_in   = ctrl_in.step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         gpr_ff       <= '{default: '0};
         opa_ff       <= '0;
         opb_ff       <= '0;
         alu_ff       <= '0;
         pc_ff        <= '0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         ctrl_ff      <= ctrl_in;
         gpr_ff       <= gpr_in;
         opa_ff       <= opa_in;
         opb_ff       <= opb_in;
         alu_ff       <= alu_in;
         pc_ff        <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_step_ff   <= rsp_step_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.halted          = rsp_halted_ff;
   assign rsp.program_counter = rsp_pc_ff;
   assign rsp.read_data       = rsp_rdata_ff;
   assign rsp.controller_step = rsp_step_ff;

endmodule

`default_nettype wire
